// ===== hdl/call_arc_count_table_defines.svh =====
// Assertion macros shared by the call-arc counting table checkers.
// Holds macro definitions only; included by files that assert.
`ifndef CALL_ARC_COUNT_TABLE_DEFINES_SVH
`define CALL_ARC_COUNT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CACT_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CACT_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cact_pkg.sv =====
// Shared types and constants for the call-arc counting table.
// No dependencies; imported by the controller, datapath, top level and checker.
`default_nettype none

package cact_pkg;

  // Default sizing of the tables.
  localparam int unsigned HEAD_DEPTH_DEF    = 4096;
  localparam int unsigned ARC_DEPTH_DEF     = 1024;
  localparam int unsigned HASH_FRACTION_DEF = 2;

  // Field widths of the stream beats and the register port.
  localparam int unsigned PC_W            = 32;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned SLOT_W          = 10;
  localparam int unsigned STATUS_W        = 3;
  localparam int unsigned ARC_LIMIT_W     = 11;
  localparam int unsigned ARC_LIMIT_RESET = 1024;
  localparam int unsigned IN_W            = 2 * PC_W;
  localparam int unsigned OUT_FIELDS_W    = STATUS_W + COUNT_W + SLOT_W;
  localparam int unsigned OUT_W           = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned ADDR_W          = 4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_HEAD     = 3'd0,
    ST_MOVED    = 3'd1,
    ST_NEW      = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  // Configuration register contents.
  typedef struct packed {
    logic                   enable;
    logic [PC_W-1:0]        text_base;
    logic [PC_W-1:0]        text_size;
    logic [ARC_LIMIT_W-1:0] arc_limit;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic check;
    logic hash;
    logic read_head;
    logic take_head;
    logic hit_head;
    logic hit_move;
    logic follow;
    logic move_link;
    logic alloc;
    logic ignore;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic in_window;
    logic in_head;
    logic head_zero;
    logic match;
    logic at_head;
    logic next_zero;
    logic walk_more;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/cact_ctrl.sv =====
// Controller state machine of the call-arc counting table.
// Depends on cact_pkg for the command and status structs.
`default_nettype none

module cact_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cact_pkg::stat_t stat,
  output cact_pkg::cmd_t  cmd
);
  import cact_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OFFSET,
    S_HASH,
    S_HEAD,
    S_HEADQ,
    S_ARC,
    S_MOVE,
    S_ALLOC,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the head table clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_OFFSET;
        end
      end
      S_OFFSET: begin
        cmd.check  = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: begin
        if (!stat.in_window) begin
          cmd.ignore = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.hash   = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!stat.in_head) begin
          cmd.ignore = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.read_head = 1'b1;
          state_next    = S_HEADQ;
        end
      end
      S_HEADQ: begin
        cmd.take_head = 1'b1;
        state_next    = stat.head_zero ? S_ALLOC : S_ARC;
      end
      S_ARC: begin
        if (stat.match && stat.at_head) begin
          cmd.hit_head = 1'b1;
          state_next   = S_EMIT;
        end else if (stat.match) begin
          cmd.hit_move = 1'b1;
          state_next   = S_MOVE;
        end else if (!stat.next_zero && stat.walk_more) begin
          cmd.follow = 1'b1;
          state_next = S_ARC;
        end else begin
          state_next = S_ALLOC;
        end
      end
      S_MOVE: begin
        cmd.move_link = 1'b1;
        state_next    = S_EMIT;
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cact_dp.sv =====
// Datapath of the call-arc counting table: window check, head hash, tables, result beat.
// Depends on cact_pkg; driven by cact_ctrl through the command and status structs.
`default_nettype none

module cact_dp #(
  parameter int unsigned HEAD_DEPTH    = cact_pkg::HEAD_DEPTH_DEF,
  parameter int unsigned ARC_DEPTH     = cact_pkg::ARC_DEPTH_DEF,
  parameter int unsigned HASH_FRACTION = cact_pkg::HASH_FRACTION_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cact_pkg::cfg_t             cfg,
  input  cact_pkg::cmd_t             cmd,
  output cact_pkg::stat_t            stat,
  input  logic [cact_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cact_pkg::OUT_W-1:0] m_tdata
);
  import cact_pkg::*;

  localparam int unsigned HEAD_AW   = $clog2(HEAD_DEPTH);
  localparam int unsigned ARC_AW    = $clog2(ARC_DEPTH);
  localparam int unsigned CNT_W     = ARC_AW + 1;
  localparam int unsigned DIVISOR   = 2 * HASH_FRACTION;
  localparam longint unsigned HEAD_SPAN = longint'(HEAD_DEPTH) * DIVISOR;
  localparam int unsigned OFF_W     = $clog2(HEAD_SPAN);
  localparam int unsigned DIV_LOG   = $clog2(DIVISOR);
  localparam int unsigned SHIFT     = OFF_W + DIV_LOG;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned RECIP_W   = OFF_W + 2;
  localparam int unsigned PROD_W    = OFF_W + RECIP_W;
  localparam int unsigned LIM_W     = (CNT_W > ARC_LIMIT_W) ? CNT_W : ARC_LIMIT_W;
  localparam int unsigned PAD_W     = OUT_W - OUT_FIELDS_W;

  // Event registers.
  logic [PC_W-1:0]    caller;
  logic [PC_W-1:0]    callee;
  logic [PC_W-1:0]    offset;
  logic               in_window;
  logic               in_head;
  logic [PROD_W-1:0]  product;
  logic [HEAD_AW-1:0] h;
  logic [HEAD_AW-1:0] quot;
  logic [PC_W:0]      diff;

  // Chain walk registers.
  logic [ARC_AW-1:0]  head;
  logic [ARC_AW-1:0]  cur;
  logic [ARC_AW-1:0]  prev;
  logic [CNT_W-1:0]   walked;
  logic [ARC_AW-1:0]  next_free;
  logic [CNT_W-1:0]   cand;
  logic               alloc_ok;
  logic               do_alloc;
  logic [HEAD_AW-1:0] clear_idx;

  // Tables and their registered read data.
  logic [ARC_AW-1:0]  head_mem [HEAD_DEPTH];
  logic [PC_W-1:0]    callee_mem [ARC_DEPTH];
  logic [COUNT_W-1:0] count_mem [ARC_DEPTH];
  logic [ARC_AW-1:0]  next_mem [ARC_DEPTH];
  logic [ARC_AW-1:0]  head_q;
  logic [PC_W-1:0]    callee_q;
  logic [COUNT_W-1:0] count_q;
  logic [ARC_AW-1:0]  next_q;

  // Table port controls.
  logic               head_we;
  logic [HEAD_AW-1:0] head_waddr;
  logic [ARC_AW-1:0]  head_wdata;
  logic [ARC_AW-1:0]  arc_raddr;
  logic               count_we;
  logic [ARC_AW-1:0]  count_waddr;
  logic [COUNT_W-1:0] count_wdata;
  logic               next_we;
  logic [ARC_AW-1:0]  next_waddr;
  logic [ARC_AW-1:0]  next_wdata;
  logic [COUNT_W-1:0] count_inc;

  // Pending result.
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;
  logic [SLOT_W-1:0]  res_slot;

  // Window check: offset from the text base, window end taken without wrap.
  assign diff = {1'b0, caller} - {1'b0, cfg.text_base};

  // Head slot: multiply by the reciprocal of the divisor, exact below the span.
  assign quot = product[SHIFT +: HEAD_AW];

  assign cand      = {1'b0, next_free} + CNT_W'(1);
  assign alloc_ok  = (LIM_W'(cand) < LIM_W'(cfg.arc_limit)) && (cand < CNT_W'(ARC_DEPTH));
  assign do_alloc  = cmd.alloc && alloc_ok;
  assign count_inc = count_q + COUNT_W'(1);

  // Event and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      caller <= s_tdata[PC_W-1:0];
      callee <= s_tdata[IN_W-1:PC_W];
    end
    if (cmd.check) begin
      offset    <= diff[PC_W-1:0];
      in_window <= cfg.enable && !diff[PC_W] && (diff[PC_W-1:0] <= cfg.text_size);
    end
    if (cmd.hash) begin
      in_head <= offset < PC_W'(HEAD_SPAN);
      product <= PROD_W'(offset[OFF_W-1:0]) * PROD_W'(RECIP);
    end
    if (cmd.read_head) begin
      h <= quot;
    end
    if (cmd.take_head) begin
      head   <= head_q;
      cur    <= head_q;
      prev   <= head_q;
      walked <= '0;
    end else if (cmd.follow) begin
      prev   <= cur;
      cur    <= next_q;
      walked <= walked + CNT_W'(1);
    end
  end

  // Allocation pointer and clearing sweep index.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= '0;
      clear_idx <= '0;
    end else begin
      if (do_alloc) begin
        next_free <= cand[ARC_AW-1:0];
      end
      if (cmd.clear_step) begin
        clear_idx <= clear_idx + HEAD_AW'(1);
      end
    end
  end

  // Head table port selection.
  always_comb begin
    head_we    = cmd.clear_step || cmd.hit_move || do_alloc;
    head_waddr = cmd.clear_step ? clear_idx : h;
    if (cmd.clear_step) begin
      head_wdata = '0;
    end else if (cmd.hit_move) begin
      head_wdata = cur;
    end else begin
      head_wdata = cand[ARC_AW-1:0];
    end
  end

  // Arc table port selection.
  always_comb begin
    if (cmd.take_head) begin
      arc_raddr = head_q;
    end else if (cmd.follow) begin
      arc_raddr = next_q;
    end else begin
      arc_raddr = cur;
    end
    count_we    = cmd.hit_head || cmd.hit_move || do_alloc;
    count_waddr = do_alloc ? cand[ARC_AW-1:0] : cur;
    count_wdata = do_alloc ? COUNT_W'(1) : count_inc;
    next_we     = cmd.hit_move || cmd.move_link || do_alloc;
    if (cmd.hit_move) begin
      next_waddr = prev;
      next_wdata = next_q;
    end else if (cmd.move_link) begin
      next_waddr = cur;
      next_wdata = head;
    end else begin
      next_waddr = cand[ARC_AW-1:0];
      next_wdata = head;
    end
  end

  // Head table memory.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[quot];
  end

  // Arc callee memory.
  always_ff @(posedge clk) begin
    if (do_alloc) begin
      callee_mem[cand[ARC_AW-1:0]] <= callee;
    end
    callee_q <= callee_mem[arc_raddr];
  end

  // Arc count memory.
  always_ff @(posedge clk) begin
    if (count_we) begin
      count_mem[count_waddr] <= count_wdata;
    end
    count_q <= count_mem[arc_raddr];
  end

  // Arc link memory.
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_q <= next_mem[arc_raddr];
  end

  // Pending result of the current event.
  always_ff @(posedge clk) begin
    if (cmd.ignore) begin
      res_status <= ST_IGNORED;
      res_count  <= '0;
      res_slot   <= '0;
    end else if (cmd.hit_head || cmd.hit_move) begin
      res_status <= cmd.hit_head ? ST_HEAD : ST_MOVED;
      res_count  <= count_inc;
      res_slot   <= SLOT_W'(cur);
    end else if (cmd.alloc) begin
      res_status <= alloc_ok ? ST_NEW : ST_OVERFLOW;
      res_count  <= alloc_ok ? COUNT_W'(1) : '0;
      res_slot   <= alloc_ok ? SLOT_W'(cand[ARC_AW-1:0]) : '0;
    end
  end

  // Output register: holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {PAD_W'(0), res_slot, res_count, res_status};
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.clear_last = clear_idx == HEAD_AW'(HEAD_DEPTH - 1);
    stat.in_window  = in_window;
    stat.in_head    = in_head;
    stat.head_zero  = head_q == '0;
    stat.match      = callee_q == callee;
    stat.at_head    = cur == head;
    stat.next_zero  = next_q == '0;
    stat.walk_more  = walked < CNT_W'(ARC_DEPTH);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

// ===== hdl/call_arc_count_table.sv =====
// Call-arc counting table. An accepted event passes the offset, hash, head read and head take
// states, then an arc state per arc examined; a deeper hit adds the move state, a miss or an
// empty chain the alloc state, and each event ends in emit before the next one is accepted.
// Ignored events skip from hash or head to emit. In emit, a result still waiting for the sink
// holds the event. After reset all HEAD_DEPTH head entries (4096 by default) are cleared with
// no event accepted; register writes are taken throughout. Uses cact_ctrl and cact_dp.
`default_nettype none

module call_arc_count_table #(
  parameter int unsigned HEAD_DEPTH    = cact_pkg::HEAD_DEPTH_DEF,
  parameter int unsigned ARC_DEPTH     = cact_pkg::ARC_DEPTH_DEF,
  parameter int unsigned HASH_FRACTION = cact_pkg::HASH_FRACTION_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Event stream.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [cact_pkg::IN_W-1:0]   s_tdata,  // caller_pc[31:0], callee_pc[63:32]
  // Result stream.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cact_pkg::OUT_W-1:0]  m_tdata,  // status[2:0], arc_count[34:3],
                                                // arc_slot[44:35], zero pad[47:45]
  // Register port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cact_pkg::ADDR_W-1:0] paddr,
  input  logic [cact_pkg::DATA_W-1:0] pwdata,
  output logic [cact_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import cact_pkg::*;

  typedef enum logic [1:0] {
    REG_ENABLE,
    REG_TEXT_BASE,
    REG_TEXT_SIZE,
    REG_ARC_LIMIT
  } reg_idx_t;

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    stat;
  reg_idx_t reg_idx;
  logic     reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= 1'b0;
      cfg.text_base <= '0;
      cfg.text_size <= '0;
      cfg.arc_limit <= ARC_LIMIT_W'(ARC_LIMIT_RESET);
    end else if (reg_wr) begin
      case (reg_idx)
        REG_ENABLE:    cfg.enable    <= pwdata[0];
        REG_TEXT_BASE: cfg.text_base <= pwdata;
        REG_TEXT_SIZE: cfg.text_size <= pwdata;
        REG_ARC_LIMIT: cfg.arc_limit <= pwdata[ARC_LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = DATA_W'(cfg.enable);
      REG_TEXT_BASE: prdata = cfg.text_base;
      REG_TEXT_SIZE: prdata = cfg.text_size;
      REG_ARC_LIMIT: prdata = DATA_W'(cfg.arc_limit);
      default:       prdata = '0;
    endcase
  end

  cact_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cact_dp #(
    .HEAD_DEPTH    (HEAD_DEPTH),
    .ARC_DEPTH     (ARC_DEPTH),
    .HASH_FRACTION (HASH_FRACTION)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/cact_checker.sv =====
// Port-level checker for the call-arc counting table, bound to the top level.
// Depends on cact_pkg and call_arc_count_table_defines.svh.
`default_nettype none
`include "call_arc_count_table_defines.svh"

module cact_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [cact_pkg::OUT_W-1:0] m_tdata
);
  import cact_pkg::*;

  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_stall;
  logic                in_beat;
  logic                no_arc;
  logic                new_arc;

  assign out_status = m_tdata[STATUS_W-1:0];
  assign out_count  = m_tdata[STATUS_W +: COUNT_W];
  assign out_slot   = m_tdata[STATUS_W + COUNT_W +: SLOT_W];

  // Qualifiers of the properties below.
  assign out_stall = m_tvalid && !m_tready;
  assign in_beat   = s_tvalid && s_tready;
  assign no_arc    = m_tvalid && (out_status == ST_IGNORED || out_status == ST_OVERFLOW);
  assign new_arc   = m_tvalid && out_status == ST_NEW;

  // A stalled result beat stays and keeps its payload.
  `CACT_ASSERT_NXT(a_out_hold, clk, rst, out_stall, m_tvalid && $stable(m_tdata), "beat not held")

  // One event at a time: acceptance closes the input until the event is done.
  `CACT_ASSERT_NXT(a_one_event, clk, rst, in_beat, !s_tready, "second event accepted back to back")

  // Ignored and overflowed events carry no arc.
  `CACT_ASSERT_IMP(a_no_arc, clk, rst, no_arc, out_count == '0 && out_slot == '0, "stray arc")

  // A freshly allocated arc starts at one in a real entry.
  `CACT_ASSERT_IMP(a_new_arc, clk, rst, new_arc, out_count == 1 && out_slot != '0, "bad new arc")

endmodule

bind call_arc_count_table cact_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/call_arc_count_table_tb.sv =====
// Self-checking testbench for the call-arc counting table: directed and random call events.
// Predicts every result beat in a behavioural copy of the arc table held in this module.
// Depends on cact_pkg and call_arc_count_table.
`default_nettype none

module call_arc_count_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cact_pkg::*;

  // Register map of the APB port.
  typedef enum logic [ADDR_W-1:0] {
    REG_ENABLE    = 4'h0,
    REG_TEXT_BASE = 4'h4,
    REG_TEXT_SIZE = 4'h8,
    REG_ARC_LIMIT = 4'hC
  } reg_addr_t;

  // One result beat; the last field sits in the lowest bits, as on m_tdata.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } arc_result_t;

  typedef enum logic {ROW_WRITE, ROW_EVENT} row_kind_t;

  // One row of the directed part: a register write or a call event.
  typedef struct {
    row_kind_t   kind;
    reg_addr_t   addr;
    logic [31:0] value;
    logic [31:0] caller;
    logic [31:0] callee;
    bit          typed;
    arc_result_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Behavioural copy of the configuration and the arc table.
  cfg_t                cfg;
  logic [SLOT_W-1:0]   chain_head [HEAD_DEPTH_DEF];
  logic [PC_W-1:0]     arc_callee_of [ARC_DEPTH_DEF];
  logic [COUNT_W-1:0]  arc_calls [ARC_DEPTH_DEF];
  logic [SLOT_W-1:0]   arc_link [ARC_DEPTH_DEF];
  logic [ARC_LIMIT_W-1:0] arcs_used;

  arc_result_t         arc_results_due [$];
  stim_row_t           directed_rows [$];
  int unsigned         mismatches = 0;
  int unsigned         results_seen = 0;
  int unsigned         hold_mark = 150;
  bit                  no_gaps = 1'b0;

  call_arc_count_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // caller_pc[31:0], callee_pc[63:32]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // status[2:0], arc_count[34:3], arc_slot[44:35], pad[47:45]
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10ns clk = ~clk;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic note_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Counts one call event in the table copy and returns the result it should give.
  function automatic arc_result_t count_call_arc(input logic [31:0] caller,
                                                 input logic [31:0] callee);
    arc_result_t            res;
    logic [32:0]            win_end;
    logic [31:0]            offset;
    int unsigned            h;
    int unsigned            steps;
    logic [SLOT_W-1:0]      head, prev, cur;
    logic [ARC_LIMIT_W-1:0] cand;
    res.status = ST_IGNORED;
    res.count  = '0;
    res.slot   = '0;
    // The window end is taken at 33 bits so that it cannot wrap.
    win_end = {1'b0, cfg.text_base} + {1'b0, cfg.text_size};
    if (!cfg.enable || caller < cfg.text_base || {1'b0, caller} > win_end) return res;
    offset = caller - cfg.text_base;
    h = offset / (2 * HASH_FRACTION_DEF);
    if (h >= HEAD_DEPTH_DEF) return res;
    head = chain_head[h];
    // Hit at the head of the chain.
    if (head != 0 && arc_callee_of[head] == callee) begin
      arc_calls[head] += 1;
      res.status = ST_HEAD;
      res.count  = arc_calls[head];
      res.slot   = head;
      return res;
    end
    // Deeper hit: bump the count and move the arc to the front.
    if (head != 0) begin
      prev = head;
      cur  = arc_link[head];
      for (steps = 0; cur != 0 && steps < ARC_DEPTH_DEF; steps++) begin
        if (arc_callee_of[cur] == callee) begin
          arc_calls[cur] += 1;
          arc_link[prev] = arc_link[cur];
          arc_link[cur]  = head;
          chain_head[h]  = cur;
          res.status = ST_MOVED;
          res.count  = arc_calls[cur];
          res.slot   = cur;
          return res;
        end
        prev = cur;
        cur  = arc_link[cur];
      end
    end
    // Miss: allocate at the front unless the limit has been reached.
    cand = arcs_used + 1'b1;
    if (cand >= cfg.arc_limit || cand >= ARC_DEPTH_DEF) begin
      res.status = ST_OVERFLOW;
      return res;
    end
    arcs_used = cand;
    arc_callee_of[cand[SLOT_W-1:0]] = callee;
    arc_calls[cand[SLOT_W-1:0]]     = 1;
    arc_link[cand[SLOT_W-1:0]]      = chain_head[h];
    chain_head[h]                   = cand[SLOT_W-1:0];
    res.status = ST_NEW;
    res.count  = 1;
    res.slot   = cand[SLOT_W-1:0];
    return res;
  endfunction

  // Idle length between beats: mostly none or short, now and then long.
  function automatic int unsigned beat_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_write(input reg_addr_t addr, input logic [31:0] value);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.addr  = addr;
    row.value = value;
    row.typed = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_event(input logic [31:0] caller, input logic [31:0] callee,
                                    input bit typed = 1'b0, input status_t st = ST_IGNORED,
                                    input logic [31:0] cnt = '0,
                                    input logic [SLOT_W-1:0] slot = '0);
    stim_row_t row;
    row.kind        = ROW_EVENT;
    row.caller      = caller;
    row.callee      = callee;
    row.typed       = typed;
    row.want.status = st;
    row.want.count  = cnt;
    row.want.slot   = slot;
    directed_rows.push_back(row);
  endfunction

  // One APB transfer: setup phase, access phase held until pready, then idle.
  task automatic reg_access(input bit wr, input reg_addr_t addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register, mirrors it in the copy and reads it back.
  task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
    logic [31:0] rd, want;
    reg_access(1'b1, addr, value, rd);
    case (addr)
      REG_ENABLE: begin
        cfg.enable = value[0];
        want = {31'b0, value[0]};
      end
      REG_TEXT_BASE: begin
        cfg.text_base = value;
        want = value;
      end
      REG_TEXT_SIZE: begin
        cfg.text_size = value;
        want = value;
      end
      REG_ARC_LIMIT: begin
        cfg.arc_limit = value[ARC_LIMIT_W-1:0];
        want = {{(32-ARC_LIMIT_W){1'b0}}, value[ARC_LIMIT_W-1:0]};
      end
      default: want = '0;
    endcase
    reg_access(1'b0, addr, '0, rd);
    if (rd !== want)
      note_mismatch($sformatf("register 0x%0h reads 0x%08h, wrote 0x%08h", addr, rd, want));
  endtask

  // Offers one call event and records the result it should produce.
  task automatic send_event(input logic [31:0] caller, input logic [31:0] callee,
                            input bit typed, input arc_result_t want, output status_t st);
    int unsigned gap;
    arc_result_t pred;
    gap = beat_gap(no_gaps);
    if (gap != 0) begin
      if (s_tvalid) s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {callee, caller};
    do @(posedge clk); while (!s_tready);
    pred = count_call_arc(caller, callee);
    arc_results_due.push_back(typed ? want : pred);
    st = pred.status;
  endtask

  // Stops offering and waits until every pending result has come back.
  task automatic drain_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (arc_results_due.size() != 0) @(posedge clk);
  endtask

  // Compares each result beat with the oldest pending result.
  always @(posedge clk) begin
    arc_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got = arc_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
      if (m_tdata[OUT_W-1:OUT_FIELDS_W] != '0) note_mismatch("padding bits of result not zero");
      if (arc_results_due.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing pending, status %0d", got.status));
      end else begin
        want = arc_results_due.pop_front();
        if (got.status !== want.status)
          note_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
        if (got.count !== want.count)
          note_mismatch($sformatf("arc_count %0d, predicted %0d", got.count, want.count));
        if (got.slot !== want.slot)
          note_mismatch($sformatf("arc_slot %0d, predicted %0d", got.slot, want.slot));
      end
    end
  end

  // Result side: random ready, clean stretches, and long hold-offs while events are offered.
  initial begin
    int unsigned len;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_seen >= hold_mark && s_tvalid) begin
        hold_mark += 250;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        m_tready <= 1'b1;
        repeat (60) @(posedge clk);
      end else begin
        len = beat_gap(1'b0);
        if (len == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          repeat (len - 1) @(posedge clk);
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then random phases of configuration and events.
  initial begin
    logic [31:0] base, size, limit, caller, callee;
    logic [31:0] head_pool [$];
    logic [31:0] callee_pool [$];
    int unsigned counted, hmax, n_items, i, r;
    status_t     st;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= REG_ENABLE;
    pwdata   <= '0;

    cfg.enable    = 1'b0;
    cfg.text_base = '0;
    cfg.text_size = '0;
    cfg.arc_limit = ARC_LIMIT_RESET;
    arcs_used     = '0;
    foreach (chain_head[k]) chain_head[k] = '0;
    foreach (arc_calls[k]) begin
      arc_callee_of[k] = '0;
      arc_calls[k]     = '0;
      arc_link[k]      = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Disabled after reset, then a one-byte window at address zero.
    add_event(32'h0000_0000, 32'h0000_0000, 1'b1, ST_IGNORED, 0, 0);
    add_write(REG_ENABLE, 32'd1);
    add_event(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_NEW, 1, 1);
    add_event(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_HEAD, 2, 1);
    add_event(32'h0000_0001, 32'h0000_0000, 1'b1, ST_IGNORED, 0, 0);
    // Largest window, whose end lies beyond 32 bits.
    add_write(REG_TEXT_BASE, 32'h8000_0000);
    add_write(REG_TEXT_SIZE, 32'hFFFF_FFFF);
    add_event(32'h7FFF_FFFF, 32'h0000_0001, 1'b1, ST_IGNORED, 0, 0);
    add_event(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, ST_IGNORED, 0, 0);
    add_event(32'h8000_4000, 32'h0000_0001, 1'b1, ST_IGNORED, 0, 0);
    // Miss on a used chain, a deeper hit, and the last head slot.
    add_event(32'h8000_0000, 32'h0000_1234);
    add_event(32'h8000_0003, 32'hFFFF_FFFF);
    add_event(32'h8000_3FFF, 32'hAAAA_5555);
    add_event(32'h8000_3FFC, 32'hAAAA_5555);
    // Smallest allocation limit: a miss overflows, hits still count.
    add_write(REG_ARC_LIMIT, 32'd1);
    add_event(32'h8000_0010, 32'h5555_AAAA, 1'b1, ST_OVERFLOW, 0, 0);
    add_event(32'h8000_0001, 32'h0000_1234);
    add_write(REG_ARC_LIMIT, 32'd1024);
    add_event(32'h8000_0010, 32'h5555_AAAA);
    // Window at the very top of the address space.
    add_write(REG_TEXT_BASE, 32'hFFFF_FFFF);
    add_event(32'hFFFF_FFFF, 32'h0000_0000);
    add_event(32'hFFFF_FFFE, 32'h0000_0000, 1'b1, ST_IGNORED, 0, 0);
    add_write(REG_TEXT_SIZE, 32'h0000_0000);
    add_write(REG_ENABLE, 32'd0);
    add_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_IGNORED, 0, 0);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        drain_results();
        write_reg(directed_rows[k].addr, directed_rows[k].value);
      end else begin
        send_event(directed_rows[k].caller, directed_rows[k].callee, directed_rows[k].typed,
                   directed_rows[k].want, st);
      end
    end

    // Random phases: a fresh window, limit and pools of call sites and targets each time.
    counted = 0;
    while (counted < 750) begin
      drain_results();
      r = $urandom_range(0, 9);
      if (r == 0) base = 32'h0000_0000;
      else if (r == 1) base = 32'hFFFF_FFFF - $urandom_range(0, 16383);
      else base = $urandom_range(0, 32'hFFFF_0000);
      r = $urandom_range(0, 9);
      if (r < 7) size = $urandom_range(16383, 24000);
      else if (r == 7) size = $urandom_range(0, 300);
      else if (r == 8) size = $urandom;
      else size = 32'hFFFF_FFFF;
      r = $urandom_range(0, 9);
      if (r < 6) limit = 1024;
      else if (r < 8) limit = (arcs_used + $urandom_range(1, 6) > 1024) ? 1024 :
                              arcs_used + $urandom_range(1, 6);
      else if (r == 8) limit = $urandom_range(1, 1024);
      else limit = 1;
      write_reg(REG_ENABLE, {31'b0, ($urandom_range(0, 7) != 0)});
      write_reg(REG_TEXT_BASE, base);
      write_reg(REG_TEXT_SIZE, size);
      write_reg(REG_ARC_LIMIT, limit);
      no_gaps = ($urandom_range(0, 5) == 0);

      hmax = ((size >> 2) > 4095) ? 4095 : (size >> 2);
      head_pool.delete();
      callee_pool.delete();
      repeat ($urandom_range(1, 6)) head_pool.push_back($urandom_range(0, hmax));
      repeat ($urandom_range(2, 10)) callee_pool.push_back($urandom);

      n_items = cfg.enable ? $urandom_range(20, 60) : $urandom_range(4, 10);
      for (i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        callee = callee_pool[$urandom_range(0, callee_pool.size() - 1)];
        if (r < 85) begin
          caller = base + head_pool[$urandom_range(0, head_pool.size() - 1)] * 4 +
                   $urandom_range(0, 3);
        end else if (r < 93) begin
          caller = $urandom;
          callee = $urandom;
        end else begin
          caller = $urandom_range(0, 1) ? base - 1 : base + size + 1;
        end
        send_event(caller, callee, 1'b0, '0, st);
        if (st != ST_IGNORED) counted++;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a result that never arrives.
  initial begin
    #60ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
